>>> src/id3cj_pkg.sv
// Package for the ID3 cover JPEG extractor: parse phases, status codes and
// the result record passed from front to back. No dependencies.
package id3cj_pkg;

   localparam int SizeWidthDefault = 32;
   localparam int QueueDepth = 4;

   typedef enum logic [3:0] {
      PH_IDLE, PH_TAG, PH_FHDR, PH_SKIP, PH_MIME,
      PH_TYPE, PH_SOI, PH_EMIT, PH_FLUSH, PH_DONE
   } phase_type;

   typedef enum logic [2:0] {
      ST_PIC    = 3'd0,
      ST_NO_TAG = 3'd1,
      ST_NO_APIC = 3'd2,
      ST_NO_MIME = 3'd3,
      ST_NOT_JPEG = 3'd4,
      ST_NO_SOI = 3'd5
   } status_type;

   // One result as it travels through the queue.
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      status_type status;
   } result_type;

endpackage

>>> src/id3cj_queue.sv
// Small FIFO between the parser and the result port.
// Depends on id3cj_pkg.
module id3cj_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  id3cj_pkg::result_type push_data,
   output logic                 full,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output id3cj_pkg::result_type pop_data
);
   localparam int AW = $clog2(id3cj_pkg::QueueDepth);

   id3cj_pkg::result_type mem_ff [id3cj_pkg::QueueDepth];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic          pop;

   assign pop       = pop_valid && pop_ready;
   assign pop_valid = (cnt_ff != '0);
   assign full      = (cnt_ff == (AW+1)'(id3cj_pkg::QueueDepth));
   assign pop_data  = mem_ff[rd_ff];

   // Pointer and count update.
   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Storage holds payload only.
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end
endmodule

>>> src/id3cj_parser.sv
// Front part: walks the tag, frame headers and APIC payload one byte a cycle while take is high.
// Depends on id3cj_pkg.
module id3cj_parser #(
   parameter int SIZE_WIDTH = id3cj_pkg::SizeWidthDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  logic [7:0]            data_byte,
   input  logic                  first_byte,
   output logic                  emit,
   output id3cj_pkg::result_type emit_data
);
   id3cj_pkg::phase_type phase_ff, phase_in, ph;
   logic [27:0] tsize_ff, tsize_in;
   logic [31:0] tpos_ff, tpos_in, tpos_c;
   logic [31:0] fsize_ff, fsize_in;
   logic [SIZE_WIDTH-1:0] fpos_ff, fpos_in, fpos_inc;
   logic [47:0] win_ff, win_in, win_sh;
   logic [3:0]  hc_ff, hc_in, hc_c;
   logic [7:0]  prev_ff, prev_in;
   logic        apic_ff, apic_in;
   logic        end_of_frame;

   assign fpos_inc     = fpos_ff + 1'b1;
   assign end_of_frame = (fpos_inc >= fsize_ff[SIZE_WIDTH-1:0]);
   assign win_sh       = {win_ff[39:0], data_byte};

   // One step of the byte parser.
   always_comb begin
      phase_in = phase_ff; tsize_in = tsize_ff; tpos_in = tpos_ff;
      fsize_in = fsize_ff; fpos_in = fpos_ff;  win_in = win_ff;
      hc_in = hc_ff; prev_in = prev_ff; apic_in = apic_ff;
      emit = 1'b0;
      emit_data = '{data: 8'd0, last: 1'b1, status: id3cj_pkg::ST_PIC};
      ph = phase_ff; hc_c = hc_ff; tpos_c = tpos_ff;
      if (first_byte) begin
         ph = id3cj_pkg::PH_TAG; hc_c = '0; tpos_c = '0;
         tsize_in = '0; fsize_in = '0; fpos_in = '0; win_in = '0;
         prev_in = '0; apic_in = 1'b0; hc_in = '0; tpos_in = '0;
         phase_in = id3cj_pkg::PH_TAG;
      end
      if (take) begin
         if ((ph == id3cj_pkg::PH_FHDR || ph == id3cj_pkg::PH_SKIP)
               && tpos_c != 32'hFFFF_FFFF)
            tpos_in = tpos_c + 1'b1;
         unique case (ph)
            id3cj_pkg::PH_TAG: begin
               if ((hc_c == 4'd0 && data_byte != 8'h49) ||
                   (hc_c == 4'd1 && data_byte != 8'h44) ||
                   (hc_c == 4'd2 && data_byte != 8'h33)) begin
                  emit = 1'b1; emit_data.status = id3cj_pkg::ST_NO_TAG;
                  phase_in = id3cj_pkg::PH_DONE;
               end else begin
                  if (hc_c >= 4'd6)
                     tsize_in = {tsize_in[20:0], data_byte[6:0]};
                  hc_in = hc_c + 1'b1;
                  if (hc_c == 4'd9) begin
                     phase_in = id3cj_pkg::PH_FHDR; hc_in = '0; tpos_in = '0;
                  end
               end
            end
            id3cj_pkg::PH_FHDR: begin
               if (hc_c == 4'd0 && tpos_c >= {4'd0, tsize_ff}) begin
                  emit = 1'b1; emit_data.status = id3cj_pkg::ST_NO_APIC;
                  phase_in = id3cj_pkg::PH_DONE;
                  tpos_in = tpos_c;
               end else begin
                  win_in = win_sh;
                  if (hc_c == 4'd3) apic_in = (win_sh[31:0] == 32'h4150_4943);
                  if (hc_c >= 4'd4 && hc_c <= 4'd7)
                     fsize_in = {fsize_ff[23:0], data_byte};
                  hc_in = hc_c + 1'b1;
                  if (hc_c == 4'd9) begin
                     fsize_in = fsize_ff & 32'((64'd1 << SIZE_WIDTH) - 1);
                     fpos_in = '0; hc_in = '0; win_in = '0;
                     if (apic_ff) begin
                        if (fsize_in == '0) begin
                           emit = 1'b1; emit_data.status = id3cj_pkg::ST_NO_MIME;
                           phase_in = id3cj_pkg::PH_DONE;
                        end else phase_in = id3cj_pkg::PH_MIME;
                     end else if (fsize_in != '0) phase_in = id3cj_pkg::PH_SKIP;
                  end
               end
            end
            id3cj_pkg::PH_SKIP: begin
               fpos_in = fpos_inc;
               if (end_of_frame) begin
                  phase_in = id3cj_pkg::PH_FHDR; hc_in = '0; fsize_in = '0;
               end
            end
            id3cj_pkg::PH_MIME: begin
               fpos_in = fpos_inc; win_in = win_sh;
               if (win_sh == 48'h696D_6167_652F) begin
                  phase_in = id3cj_pkg::PH_TYPE; hc_in = '0; win_in = '0;
                  if (end_of_frame) begin
                     emit = 1'b1; emit_data.status = id3cj_pkg::ST_NOT_JPEG;
                     phase_in = id3cj_pkg::PH_DONE;
                  end
               end else if (end_of_frame) begin
                  emit = 1'b1; emit_data.status = id3cj_pkg::ST_NO_MIME;
                  phase_in = id3cj_pkg::PH_DONE;
               end
            end
            id3cj_pkg::PH_TYPE: begin
               fpos_in = fpos_inc; win_in = win_sh; hc_in = hc_c + 1'b1;
               if ((hc_c == 4'd2 && (win_sh[23:0] == 24'h6A7067 ||
                                     win_sh[23:0] == 24'h706567)) ||
                   (hc_c >= 4'd3 && data_byte == 8'h67)) begin
                  hc_in = '0; phase_in = id3cj_pkg::PH_SOI;
                  if (end_of_frame) begin
                     emit = 1'b1; emit_data.status = id3cj_pkg::ST_NO_SOI;
                     phase_in = id3cj_pkg::PH_DONE;
                  end
               end else if ((hc_c == 4'd2 && win_sh[23:0] != 24'h6A7065) ||
                            hc_c >= 4'd3 || end_of_frame) begin
                  emit = 1'b1; emit_data.status = id3cj_pkg::ST_NOT_JPEG;
                  phase_in = id3cj_pkg::PH_DONE;
               end
            end
            id3cj_pkg::PH_SOI: begin
               fpos_in = fpos_inc; prev_in = data_byte;
               if (hc_c != '0 && prev_ff == 8'hFF && data_byte == 8'hD8) begin
                  emit = 1'b1;
                  emit_data = '{data: 8'hFF, last: 1'b0, status: id3cj_pkg::ST_PIC};
                  phase_in = end_of_frame ? id3cj_pkg::PH_FLUSH : id3cj_pkg::PH_EMIT;
               end else begin
                  hc_in = 4'd1;
                  if (end_of_frame) begin
                     emit = 1'b1; emit_data.status = id3cj_pkg::ST_NO_SOI;
                     phase_in = id3cj_pkg::PH_DONE;
                  end
               end
            end
            id3cj_pkg::PH_EMIT: begin
               emit = 1'b1;
               emit_data = '{data: prev_ff, last: 1'b0, status: id3cj_pkg::ST_PIC};
               prev_in = data_byte; fpos_in = fpos_inc;
               if (end_of_frame) phase_in = id3cj_pkg::PH_FLUSH;
            end
            id3cj_pkg::PH_FLUSH: begin
               emit = 1'b1;
               emit_data = '{data: prev_ff, last: 1'b1, status: id3cj_pkg::ST_PIC};
               phase_in = id3cj_pkg::PH_DONE;
            end
            default: ;
         endcase
      end else if (first_byte) begin
         phase_in = phase_ff; tsize_in = tsize_ff; tpos_in = tpos_ff;
         fsize_in = fsize_ff; fpos_in = fpos_ff; win_in = win_ff;
         hc_in = hc_ff; prev_in = prev_ff; apic_in = apic_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= id3cj_pkg::PH_IDLE;
         tsize_ff <= '0; tpos_ff <= '0; fsize_ff <= '0; fpos_ff <= '0;
         win_ff <= '0; hc_ff <= '0; prev_ff <= '0; apic_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         tsize_ff <= tsize_in; tpos_ff <= tpos_in; fsize_ff <= fsize_in;
         fpos_ff <= fpos_in; win_ff <= win_in; hc_ff <= hc_in;
         prev_ff <= prev_in; apic_ff <= apic_in;
      end
   end
endmodule

>>> src/id3_cover_jpeg_extractor.sv
// Top level of the ID3 cover JPEG extractor: byte parser feeding a result FIFO.
// Depends on id3cj_pkg, id3cj_parser and id3cj_queue.
// A result enters the FIFO at the edge that accepts its request and is
// offered on rsp_ once it is at the FIFO head. Throughput: one request per cycle while
// the four-entry FIFO has room. Synchronous reset returns to idle, FIFO empty.
module id3_cover_jpeg_extractor #(
   parameter int SIZE_WIDTH = id3cj_pkg::SizeWidthDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_first_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_picture,
   output logic [2:0] rsp_status
);
   logic                  take, emit, full;
   id3cj_pkg::result_type emit_data, head;

   // Stall requests only when the FIFO cannot take a result.
   assign req_ready = !full;
   assign take      = req_valid && req_ready;

   id3cj_parser #(.SIZE_WIDTH(SIZE_WIDTH)) u_parser (
      .clock, .reset, .take,
      .data_byte(req_data_byte), .first_byte(req_first_byte && take),
      .emit, .emit_data
   );

   id3cj_queue u_queue (
      .clock, .reset, .push(emit && take), .push_data(emit_data), .full,
      .pop_valid(rsp_valid), .pop_ready(rsp_ready), .pop_data(head)
   );

   assign rsp_out_byte        = head.data;
   assign rsp_last_of_picture = head.last;
   assign rsp_status          = head.status;
endmodule
